>>> rtl/wpm_pkg.sv
// Shared constants, types and symbol-compare function for the wildcard pattern matcher.
`default_nettype none

package wpm_pkg;

	localparam int PAT_BYTES = 16;
	localparam int PAT_W     = PAT_BYTES * 8;
	localparam int LEN_W     = 5;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

	localparam logic [7:0] CH_STAR     = 8'h2A;
	localparam logic [7:0] CH_QMARK    = 8'h3F;
	localparam logic [7:0] CH_HASH     = 8'h23;
	localparam logic [7:0] CH_DOLLAR   = 8'h24;
	localparam logic [7:0] CH_DIGIT_LO = 8'd48;
	localparam logic [7:0] CH_DIGIT_HI = 8'd57;
	localparam logic [7:0] CH_UPPER_LO = 8'h41;
	localparam logic [7:0] CH_UPPER_HI = 8'h5A;
	localparam logic [7:0] CH_DASH     = 8'h2D;

	typedef struct packed {
		logic hit;        // final pattern position active after closure
		logic wild_char;  // current text byte is '*' or '?'
	} wpm_flags_t;

	// One pattern symbol against one text byte ('*' is handled by the caller).
	function automatic logic sym_accepts(input logic [7:0] p, input logic [7:0] c);
		logic r;
		if (p == CH_QMARK) begin
			r = 1'b1;
		end else if (p == CH_HASH) begin
			r = ((c >= CH_DIGIT_LO) && (c <= CH_DIGIT_HI)) || (c == CH_DASH);
		end else if (p == CH_DOLLAR) begin
			r = (c >= CH_UPPER_LO) && (c <= CH_UPPER_HI);
		end else begin
			r = (p == c);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/wpm_step.sv
// NFA step: star closure of the active vector, verdict bit and next active vector.
`default_nettype none

module wpm_step
	import wpm_pkg::*;
#(
	parameter int PATTERN_MAX = 16
) (
	input  wire logic [PAT_W-1:0]       pattern,
	input  wire logic [LEN_W-1:0]       pattern_length,
	input  wire logic [PATTERN_MAX:0]   active,
	input  wire logic [7:0]             char_code,
	output logic      [PATTERN_MAX:0]   next_active,
	output wpm_flags_t                  flags
);

	logic [LEN_W-1:0]       len_c;
	logic [PATTERN_MAX-1:0] used;
	logic [PATTERN_MAX-1:0] star;
	logic [PATTERN_MAX-1:0] acc;
	logic [PATTERN_MAX:0]   closed;
	logic [PATTERN_MAX:0]   len_sel;
	logic [PATTERN_MAX:0]   next_raw;

	// lengths past the array size clamp to the array size
	assign len_c = (pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
		: pattern_length;

	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			used[i] = LEN_W'(i) < len_c;
			star[i] = pattern[i*8 +: 8] == CH_STAR;
			acc[i]  = sym_accepts(pattern[i*8 +: 8], char_code);
		end
	end

	// star closure: a live '*' also makes the following position live
	always_comb begin
		closed[0] = active[0];
		for (int i = 0; i < PATTERN_MAX; i++) begin
			closed[i+1] = active[i+1] | (closed[i] & used[i] & star[i]);
		end
	end

	always_comb begin
		for (int i = 0; i <= PATTERN_MAX; i++) begin
			len_sel[i] = LEN_W'(i) == len_c;
		end
	end

	// '*' holds its position, any other accepting symbol advances by one
	always_comb begin
		next_raw = '0;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (closed[i] && used[i]) begin
				if (star[i]) begin
					next_raw[i] = 1'b1;
				end else if (acc[i]) begin
					next_raw[i+1] = 1'b1;
				end
			end
		end
	end

	// close the new vector under the pattern in use for this byte
	always_comb begin
		next_active[0] = next_raw[0];
		for (int i = 0; i < PATTERN_MAX; i++) begin
			next_active[i+1] = next_raw[i+1] | (next_active[i] & used[i] & star[i]);
		end
	end

	assign flags.hit       = |(closed & len_sel);
	assign flags.wild_char = (char_code == CH_STAR) || (char_code == CH_QMARK);

endmodule

`default_nettype wire

>>> rtl/wildcard_pattern_matcher.sv
// Top level: streamed-text glob matcher with request register, NFA state and result register.
`default_nettype none

// Usage
//   Input channel (in_valid/in_ready): one request per text byte in char_code, or an
//   end-of-text request with end_of_text high (char_code then ignored).
//   Output channel (out_valid/out_ready): one result per end-of-text request with
//   matched and wildcard_in_text. Byte requests give no result.
//   Config port: cfg_write with cfg_index 0/1 loads pattern bytes 0-7 / 8-15 (byte 0
//   in bits 7:0), index 2 loads pattern_length from cfg_data[4:0]. Write only while
//   idle; the new pattern applies to the next request.
// Timing
//   A request lands in the input register at its accept edge and is processed by one
//   pass of compare and star-closure logic while it sits there; an end-of-text result
//   is registered in the output register when that request leaves the input register.
//   One request per cycle is sustained while no end-of-text request is stalled; the
//   single-pass NFA update over PATTERN_MAX positions sets that rate.
// Reset and stall
//   Reset clears the pattern, sets only position zero active and clears the wildcard
//   flag; no clearing pass is needed. When the receiver stalls, byte requests keep
//   flowing until an end-of-text request reaches the input register; it waits there
//   until the output register frees, and in_ready is low only while it waits.
module wildcard_pattern_matcher
	import wpm_pkg::*;
#(
	parameter int PATTERN_MAX = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           char_code,
	input  wire logic                 end_of_text,

	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      matched,
	output logic                      wildcard_in_text,

	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam logic [PATTERN_MAX:0] ACTIVE_RESET = (PATTERN_MAX+1)'(1);

	// config
	logic [CFG_W-1:0]     pat_low_q;
	logic [CFG_W-1:0]     pat_high_q;
	logic [LEN_W-1:0]     pat_len_q;

	// input register
	logic                 valid_s1;
	logic [7:0]           char_s1;
	logic                 eot_s1;

	// NFA state
	logic [PATTERN_MAX:0] active_q;
	logic                 wild_q;

	// result register
	logic                 out_valid_s2;
	logic                 matched_s2;
	logic                 wild_s2;

	logic [PATTERN_MAX:0] next_active;
	wpm_flags_t           flags;
	logic                 out_free;
	logic                 adv_s1;
	logic                 in_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PAT_LOW:  pat_low_q  <= cfg_data;
				REG_PAT_HIGH: pat_high_q <= cfg_data;
				REG_PAT_LEN:  pat_len_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// byte requests never need the output; end requests need a free result slot
	assign out_free = !out_valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && (!eot_s1 || out_free);
	assign in_ready = !valid_s1 || adv_s1;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			char_s1 <= char_code;
			eot_s1  <= end_of_text;
		end
	end

	wpm_step #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_step (
		.pattern        ({pat_high_q, pat_low_q}),
		.pattern_length (pat_len_q),
		.active         (active_q),
		.char_code      (char_s1),
		.next_active    (next_active),
		.flags          (flags)
	);

	// state holds the vector closed after each byte; the read side closes it
	// again so a pattern change takes effect at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
			wild_q   <= 1'b0;
		end else if (adv_s1) begin
			if (eot_s1) begin
				active_q <= ACTIVE_RESET;
				wild_q   <= 1'b0;
			end else begin
				active_q <= next_active;
				wild_q   <= wild_q | flags.wild_char;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv_s1 && eot_s1) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && eot_s1) begin
			matched_s2 <= flags.hit && !wild_q;
			wild_s2    <= wild_q;
		end
	end

	assign out_valid        = out_valid_s2;
	assign matched          = matched_s2;
	assign wildcard_in_text = wild_s2;

	// an end request restarts the match
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && eot_s1) |=> (active_q == ACTIVE_RESET && !wild_q))
		else $error("match state not restarted after end of text");

	// a wildcard in the text always forces a miss
	a_wild_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> !(matched_s2 && wild_s2))
		else $error("match reported for text holding a wildcard");

	// back-pressure only from a stalled end request
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && eot_s1 && out_valid_s2 && !out_ready))
		else $error("input stalled without a blocked end request");

	// a new result only comes from an end request leaving the input register
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_s2) |-> $past(valid_s1 && eot_s1))
		else $error("result produced without an end request");

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the wildcard pattern matcher: directed, random and backpressure tests.

module testbench;
	import wpm_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic matched;
		logic wild;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] char_code;
	logic end_of_text;
	logic out_valid;
	logic out_ready;
	logic matched;
	logic wildcard_in_text;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	wildcard_pattern_matcher u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.char_code        (char_code),
		.end_of_text      (end_of_text),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.matched          (matched),
		.wildcard_in_text (wildcard_in_text),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #5 clk = ~clk;

	// Predictor state: pattern registers as last written, NFA positions, wildcard flag
	logic [63:0] pat_lo_m;
	logic [63:0] pat_hi_m;
	logic [4:0] pat_len_m;
	logic [16:0] nfa_m;
	logic wild_m;

	verdict_t verdicts_due[$];
	verdict_t want_v;
	verdict_t got_v;
	logic [7:0] text_buf[$];
	string plain_set = "ab-0Z9A";

	int mismatches = 0;
	int items_sent = 0;
	int cycle_count = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int rx_hold = 0;
	int stall_left = 0;

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 70) return $urandom_range(2);
		if (r < 95) return $urandom_range(8, 3);
		return $urandom_range(60, 20);
	endfunction

	function automatic int live_len();
		return (pat_len_m > 5'd16) ? 16 : int'(pat_len_m);
	endfunction

	function automatic logic [7:0] pat_at(int i);
		if (i < 8) return pat_lo_m[i*8 +: 8];
		return pat_hi_m[(i-8)*8 +: 8];
	endfunction

	// Epsilon moves: an active '*' position also activates the next one
	function automatic logic [16:0] star_close(logic [16:0] s, int len);
		for (int i = 0; i < len; i++)
			if (s[i] && pat_at(i) == CH_STAR) s[i+1] = 1'b1;
		return s;
	endfunction

	function automatic logic symbol_hit(logic [7:0] p, logic [7:0] c);
		case (p)
			CH_QMARK: return 1'b1;
			CH_HASH: return (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) || c == CH_DASH;
			CH_DOLLAR: return c >= CH_UPPER_LO && c <= CH_UPPER_HI;
			default: return p == c;
		endcase
	endfunction

	function automatic logic [16:0] nfa_advance(logic [16:0] s, logic [7:0] c, int len);
		logic [16:0] nxt;
		logic [7:0] p;
		nxt = '0;
		for (int i = 0; i < len; i++) begin
			if (s[i]) begin
				p = pat_at(i);
				if (p == CH_STAR) nxt[i] = 1'b1;
				else if (symbol_hit(p, c)) nxt[i+1] = 1'b1;
			end
		end
		return star_close(nxt, len);
	endfunction

	// Update the predictor for one accepted request; end requests queue a verdict
	task automatic track_request(input logic [7:0] c, input logic eot);
		int len;
		logic [16:0] s;
		verdict_t v;
		len = live_len();
		s = star_close(nfa_m, len);
		if (eot) begin
			v.matched = s[len] && !wild_m;
			v.wild = wild_m;
			verdicts_due.push_back(v);
			nfa_m = 17'd1;
			wild_m = 1'b0;
		end else begin
			nfa_m = nfa_advance(s, c, len);
			if (c == CH_STAR || c == CH_QMARK) wild_m = 1'b1;
		end
	endtask

	// Sender: called and returns at a falling edge
	task automatic send_req(input logic [7:0] c, input logic eot);
		int gap;
		gap = ($urandom_range(99) < tx_idle_pct) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		end_of_text <= eot;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		track_request(c, eot);
		items_sent++;
		@(negedge clk);
	endtask

	// Text in text_buf, then the end request (its byte is junk and must be ignored)
	task automatic send_text_buf();
		foreach (text_buf[i]) send_req(text_buf[i], 1'b0);
		send_req(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic send_text(input string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
		send_text_buf();
	endtask

	// Stop offering, wait for all verdicts, then let trailing byte requests settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi, input int len);
		logic [63:0] junk;
		wait_idle();
		junk = {$urandom, $urandom};
		cfg_write <= 1'b1;
		cfg_index <= REG_PAT_LOW;
		cfg_data <= lo;
		@(negedge clk);
		cfg_index <= REG_PAT_HIGH;
		cfg_data <= hi;
		@(negedge clk);
		cfg_index <= REG_PAT_LEN;
		cfg_data <= {junk[63:5], 5'(len)};
		@(negedge clk);
		cfg_write <= 1'b0;
		pat_lo_m = lo;
		pat_hi_m = hi;
		pat_len_m = 5'(len);
	endtask

	function automatic logic [127:0] pat_from(input string s);
		logic [127:0] v;
		v = '0;
		for (int i = 0; i < s.len(); i++) v[i*8 +: 8] = s[i];
		return v;
	endfunction

	function automatic logic [7:0] rand_plain();
		if ($urandom_range(99) < 75) return plain_set[$urandom_range(plain_set.len() - 1)];
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] pick_symbol();
		int r;
		r = $urandom_range(99);
		if (r < 20) return CH_STAR;
		if (r < 32) return CH_QMARK;
		if (r < 44) return CH_HASH;
		if (r < 56) return CH_DOLLAR;
		if (r < 90) return plain_set[$urandom_range(4)];
		return 8'($urandom_range(255));
	endfunction

	// Mostly short lengths; empty, full and over-range ones now and then
	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 10) return 0;
		if (r < 20) return 16;
		if (r < 28) return $urandom_range(31, 17);
		return $urandom_range(8, 1);
	endfunction

	// Mostly texts built to fit the pattern, some mutated, the rest noise
	task automatic build_text();
		int len;
		int k;
		logic [7:0] p;
		text_buf.delete();
		len = live_len();
		if ($urandom_range(99) < 75) begin
			for (int i = 0; i < len; i++) begin
				p = pat_at(i);
				case (p)
					CH_STAR: repeat ($urandom_range(3)) text_buf.push_back(rand_plain());
					CH_QMARK: text_buf.push_back(rand_plain());
					CH_HASH: begin
						k = $urandom_range(10);
						text_buf.push_back((k == 10) ? CH_DASH : CH_DIGIT_LO + 8'(k));
					end
					CH_DOLLAR: text_buf.push_back(CH_UPPER_LO + 8'($urandom_range(25)));
					default: text_buf.push_back(p);
				endcase
			end
			if ($urandom_range(99) < 25 && text_buf.size() > 0) begin
				k = $urandom_range(text_buf.size() - 1);
				case ($urandom_range(2))
					0: text_buf[k] = rand_plain();
					1: text_buf.delete(k);
					default: text_buf.insert(k, rand_plain());
				endcase
			end
			if ($urandom_range(99) < 5)
				text_buf.insert($urandom_range(text_buf.size()),
					$urandom_range(1) ? CH_STAR : CH_QMARK);
		end else begin
			repeat ($urandom_range(8)) text_buf.push_back(rand_plain());
		end
	endtask

	task automatic test_directed();
		logic [127:0] v;
		// empty text against the empty pattern left by reset
		send_req(8'hFF, 1'b1);
		// star must give back characters: '*ab' on 'aab'
		v = pat_from("*ab");
		load_pattern(v[63:0], v[127:64], 3);
		send_text("aab");
		// class symbols at the edges of their ranges, '?' on byte 255
		v = pat_from("##$$?");
		load_pattern(v[63:0], v[127:64], 5);
		text_buf.delete();
		text_buf = '{"-", "9", "A", "Z", 8'hFF};
		send_text_buf();
		send_text("0-[");
		send_text("/");
		// zero bytes are ordinary in both pattern and text
		load_pattern(64'h2A00, 64'h0, 2);
		text_buf = '{8'h00, "q"};
		send_text_buf();
		// text holding '?' never matches
		text_buf = '{8'h00, CH_QMARK};
		send_text_buf();
		// length above maximum is clamped; empty text on all-star pattern
		v = pat_from("****************");
		load_pattern(v[63:0], v[127:64], 31);
		send_req(8'h00, 1'b1);
		// bytes beyond the length are ignored
		v = pat_from("xyyyyyyyyyyyyyyy");
		load_pattern(v[63:0], v[127:64], 1);
		send_text("x");
	endtask

	task automatic test_random_patterns();
		int target;
		int phase;
		int r;
		logic [127:0] v;
		target = items_sent + 1200;
		phase = 0;
		while (items_sent < target) begin
			// rotate idling profiles, including one with none at all
			case (phase % 4)
				0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
				1: begin tx_idle_pct = 20; rx_stall_pct = 20; end
				2: begin tx_idle_pct = 50; rx_stall_pct = 10; end
				default: begin tx_idle_pct = 10; rx_stall_pct = 50; end
			endcase
			r = $urandom_range(99);
			if (r < 5) v = '0;
			else if (r < 10) v = '1;
			else for (int i = 0; i < 16; i++) v[i*8 +: 8] = pick_symbol();
			load_pattern(v[63:0], v[127:64], pick_len());
			repeat (30) begin
				build_text();
				send_text_buf();
			end
			phase++;
		end
	endtask

	// Receiver holds off long enough for end requests to back up into the input
	task automatic test_backpressure();
		logic [127:0] v;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		v = pat_from("a*#");
		load_pattern(v[63:0], v[127:64], 3);
		rx_hold = 200;
		repeat (40) begin
			build_text();
			send_text_buf();
		end
		// sender pauses until every verdict is back
		wait_idle();
		tx_idle_pct = 30;
		rx_stall_pct = 30;
		repeat (20) begin
			build_text();
			send_text_buf();
		end
	endtask

	// Receiver: random stalls plus an explicit hold-off count
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if ($urandom_range(99) < rx_stall_pct) begin
				stall_left = pick_gap();
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Verdict checker: every accepted result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_v.matched = matched;
			got_v.wild = wildcard_in_text;
			if (verdicts_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected verdict: matched=%0b wildcard_in_text=%0b",
						got_v.matched, got_v.wild);
			end else begin
				want_v = verdicts_due.pop_front();
				if (got_v.matched !== want_v.matched || got_v.wild !== want_v.wild) begin
					mismatches++;
					if (mismatches <= 10)
						$display("verdict mismatch (matched/wildcard): exp %0b/%0b got %0b/%0b",
							want_v.matched, want_v.wild, got_v.matched, got_v.wild);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = 8'h00;
		end_of_text = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_PAT_LOW;
		cfg_data = '0;
		pat_lo_m = '0;
		pat_hi_m = '0;
		pat_len_m = '0;
		nfa_m = 17'd1;
		wild_m = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		tx_idle_pct = 20;
		rx_stall_pct = 20;
		test_directed();
		test_random_patterns();
		test_backpressure();
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0 && verdicts_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
